// File: hw/rtl/uda_pkg.sv
// shared types and constants for the uint4 dot product accumulator
`default_nettype none

package uda_pkg;

    // register byte addresses on the configuration port
    localparam logic [2:0] ADDR_CENTERED_MODE = 3'd0;
    localparam logic [2:0] ADDR_ZERO_POINT    = 3'd4;

    // register reset values
    localparam logic [3:0] ZERO_POINT_RESET = 4'd8;
    localparam logic [7:0] ZP_SQUARE_RESET  = 8'd64;

    // fixed field widths
    localparam int unsigned NIBBLE_W = 4;
    localparam int unsigned PROD_W   = 8;
    localparam int unsigned PSUM_W   = 24;
    localparam int unsigned OPSUM_W  = 20;
    localparam int unsigned COUNT_W  = 17;
    localparam int unsigned RESULT_W = 25;

    // one input beat
    typedef struct packed {
        logic [63:0] a_nibbles;
        logic [63:0] b_nibbles;
        logic [4:0]  valid_lanes;
        logic        last_group;
    } t_in_beat;

    // one result beat
    typedef struct packed {
        logic signed [RESULT_W-1:0] dot_result;
        logic [COUNT_W-1:0]         element_total;
        logic                       overflow;
    } t_out_beat;

    // what one lane hands to the merge stage
    typedef struct packed {
        logic [PROD_W-1:0]   prod;
        logic [NIBBLE_W-1:0] a_val;
        logic [NIBBLE_W-1:0] b_val;
    } t_lane_out;

endpackage

`default_nettype wire

// File: hw/rtl/uda_lane.sv
// one multiply lane: 4x4 product of an operand pair, zeroed when the lane is unused
`default_nettype none

module uda_lane (
    input  wire logic [3:0]         i_a,
    input  wire logic [3:0]         i_b,
    input  wire logic               i_lane_en,
    output uda_pkg::t_lane_out      o_lane
);

    // product and masked operands
    always_comb begin
        o_lane = '0;
        if (i_lane_en) begin
            o_lane.prod  = {4'b0, i_a} * {4'b0, i_b};
            o_lane.a_val = i_a;
            o_lane.b_val = i_b;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/uda_merge.sv
// merge stage: adds the lane products and operands of one beat into registered group sums
`default_nettype none

module uda_merge #(
    parameter int unsigned LANES = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire logic                                  i_valid,
    input  wire uda_pkg::t_lane_out [LANES-1:0]        i_lanes,
    input  wire logic [$clog2(LANES+1)-1:0]            i_count,
    input  wire logic                                  i_last,
    output logic                                       o_valid,
    output logic [uda_pkg::PROD_W+$clog2(LANES)-1:0]   o_psum,
    output logic [uda_pkg::NIBBLE_W+$clog2(LANES)-1:0] o_asum,
    output logic [uda_pkg::NIBBLE_W+$clog2(LANES)-1:0] o_bsum,
    output logic [$clog2(LANES+1)-1:0]                 o_count,
    output logic                                       o_last
);

    localparam int unsigned PS_W = uda_pkg::PROD_W + $clog2(LANES);
    localparam int unsigned OS_W = uda_pkg::NIBBLE_W + $clog2(LANES);

    logic [PS_W-1:0] n_psum;
    logic [OS_W-1:0] n_asum;
    logic [OS_W-1:0] n_bsum;
    logic            r_valid;

    // sum across lanes
    always_comb begin
        n_psum = '0;
        n_asum = '0;
        n_bsum = '0;
        for (int i = 0; i < LANES; i++) begin
            n_psum = n_psum + PS_W'(i_lanes[i].prod);
            n_asum = n_asum + OS_W'(i_lanes[i].a_val);
            n_bsum = n_bsum + OS_W'(i_lanes[i].b_val);
        end
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // group sums
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_psum  <= n_psum;
            o_asum  <= n_asum;
            o_bsum  <= n_bsum;
            o_count <= i_count;
            o_last  <= i_last;
        end
    end

    assign o_valid = r_valid;

endmodule

`default_nettype wire

// File: hw/rtl/uint4_dot_product_accumulator_core.sv
// top level of the uint4 dot product accumulator
//
// Input beats (i_valid, o_stall, i_in) carry up to LANES pairs of unsigned
// nibbles plus a lane count and a last mark. A beat is taken at a rising edge
// with i_valid high and o_stall low; one beat can be taken every cycle.
// LANES multiply lanes feed a registered merge tree, then a running
// accumulator adds the group sums of product, A, B and element count.
// A beat marked last closes the dot product: its totals go through a
// correction stage (three products against the zero point, then one add)
// and a result beat appears on (o_valid, i_stall, o_out) after the merge,
// snapshot, correction and result registers. The accumulator clears as the
// snapshot is taken, so the next dot product may start in the following cycle.
// A group that would take the count above MAX_LEN is dropped and sets the
// overflow bit of the result.
// While a result waits with i_stall high the whole pipeline holds and
// o_stall is raised; nothing is lost or repeated.
// Synchronous active-low reset empties the pipeline, clears the
// accumulators, sets centered_mode to 0 and zero_point to 8.
// APB registers: centered_mode at 0x0, zero_point at 0x4; pready is always high.
`default_nettype none

module uint4_dot_product_accumulator_core #(
    parameter int unsigned LANES   = 16,
    parameter int unsigned MAX_LEN = 65536
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input channel
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire uda_pkg::t_in_beat  i_in,
    // result channel
    output logic                    o_valid,
    input  wire logic               i_stall,
    output uda_pkg::t_out_beat      o_out,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int unsigned CNT_W = $clog2(LANES + 1);
    localparam int unsigned PS_W  = uda_pkg::PROD_W + $clog2(LANES);
    localparam int unsigned OS_W  = uda_pkg::NIBBLE_W + $clog2(LANES);
    localparam int unsigned ACC_W = uda_pkg::PSUM_W;
    localparam int unsigned OPS_W = uda_pkg::OPSUM_W;
    localparam int unsigned CW    = uda_pkg::COUNT_W;
    localparam int unsigned RW    = uda_pkg::RESULT_W;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic       r_centered;
    logic [3:0] r_zp;
    logic [7:0] r_zp_sq;
    logic       cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    // register writes, zero point square kept alongside
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centered <= 1'b0;
            r_zp       <= uda_pkg::ZERO_POINT_RESET;
            r_zp_sq    <= uda_pkg::ZP_SQUARE_RESET;
        end else if (cfg_wr) begin
            case (paddr)
                uda_pkg::ADDR_CENTERED_MODE: begin
                    r_centered <= pwdata[0];
                end
                uda_pkg::ADDR_ZERO_POINT: begin
                    r_zp    <= pwdata[3:0];
                    r_zp_sq <= {4'b0, pwdata[3:0]} * {4'b0, pwdata[3:0]};
                end
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr)
            uda_pkg::ADDR_CENTERED_MODE: prdata = {31'b0, r_centered};
            uda_pkg::ADDR_ZERO_POINT:    prdata = {28'b0, r_zp};
            default:                     prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // pipeline advance: everything holds while a result is stalled
    // ---------------------------------------------------------------
    logic r_out_valid;
    logic en;

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    // ---------------------------------------------------------------
    // lanes
    // ---------------------------------------------------------------
    uda_pkg::t_lane_out [LANES-1:0] lane_out;
    logic [CNT_W-1:0]               in_count;

    // lane count saturated to the lane number
    assign in_count = (i_in.valid_lanes > 5'(LANES)) ? CNT_W'(LANES)
                                                     : i_in.valid_lanes[CNT_W-1:0];

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        uda_lane u_lane (
            .i_a       (i_in.a_nibbles[4*g +: 4]),
            .i_b       (i_in.b_nibbles[4*g +: 4]),
            .i_lane_en (5'(g) < i_in.valid_lanes),
            .o_lane    (lane_out[g])
        );
    end

    // ---------------------------------------------------------------
    // merge stage
    // ---------------------------------------------------------------
    logic             s1_valid;
    logic [PS_W-1:0]  s1_psum;
    logic [OS_W-1:0]  s1_asum;
    logic [OS_W-1:0]  s1_bsum;
    logic [CNT_W-1:0] s1_count;
    logic             s1_last;

    uda_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_lanes (lane_out),
        .i_count (in_count),
        .i_last  (i_in.last_group),
        .o_valid (s1_valid),
        .o_psum  (s1_psum),
        .o_asum  (s1_asum),
        .o_bsum  (s1_bsum),
        .o_count (s1_count),
        .o_last  (s1_last)
    );

    // ---------------------------------------------------------------
    // running accumulator
    // ---------------------------------------------------------------
    logic [ACC_W-1:0] r_product_sum, n_product_sum;
    logic [OPS_W-1:0] r_a_total, n_a_total;
    logic [OPS_W-1:0] r_b_total, n_b_total;
    logic [CW-1:0]    r_pair_count, n_pair_count;
    logic             r_overflow, n_overflow;
    logic             grp_over;
    logic             s1_fire;

    assign s1_fire  = s1_valid && en;
    assign grp_over = ({1'b0, r_pair_count} + (CW+1)'(s1_count)) > (CW+1)'(MAX_LEN);

    // totals including the current group, unless it is refused
    always_comb begin
        n_product_sum = r_product_sum;
        n_a_total     = r_a_total;
        n_b_total     = r_b_total;
        n_pair_count  = r_pair_count;
        n_overflow    = r_overflow;
        if (grp_over) begin
            n_overflow = 1'b1;
        end else begin
            n_product_sum = r_product_sum + ACC_W'(s1_psum);
            n_a_total     = r_a_total + OPS_W'(s1_asum);
            n_b_total     = r_b_total + OPS_W'(s1_bsum);
            n_pair_count  = r_pair_count + CW'(s1_count);
        end
    end

    // accumulate, clear on the last group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_product_sum <= '0;
            r_a_total     <= '0;
            r_b_total     <= '0;
            r_pair_count  <= '0;
            r_overflow    <= 1'b0;
        end else if (s1_fire) begin
            if (s1_last) begin
                r_product_sum <= '0;
                r_a_total     <= '0;
                r_b_total     <= '0;
                r_pair_count  <= '0;
                r_overflow    <= 1'b0;
            end else begin
                r_product_sum <= n_product_sum;
                r_a_total     <= n_a_total;
                r_b_total     <= n_b_total;
                r_pair_count  <= n_pair_count;
                r_overflow    <= n_overflow;
            end
        end
    end

    // ---------------------------------------------------------------
    // snapshot of the finished totals
    // ---------------------------------------------------------------
    logic             r_s2_valid;
    logic [ACC_W-1:0] r_s2_psum;
    logic [OPS_W-1:0] r_s2_a;
    logic [OPS_W-1:0] r_s2_b;
    logic [CW-1:0]    r_s2_count;
    logic             r_s2_over;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= s1_valid && s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_psum  <= n_product_sum;
            r_s2_a     <= n_a_total;
            r_s2_b     <= n_b_total;
            r_s2_count <= n_pair_count;
            r_s2_over  <= n_overflow;
        end
    end

    // ---------------------------------------------------------------
    // zero point correction products
    // ---------------------------------------------------------------
    logic          r_s3_valid;
    logic [RW-1:0] r_s3_psum;
    logic [RW-1:0] r_s3_pa;
    logic [RW-1:0] r_s3_pb;
    logic [RW-1:0] r_s3_pc;
    logic [CW-1:0] r_s3_count;
    logic          r_s3_over;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (en) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_psum  <= RW'(r_s2_psum);
            r_s3_pa    <= {(RW-4)'(0), r_zp} * {(RW-OPS_W)'(0), r_s2_a};
            r_s3_pb    <= {(RW-4)'(0), r_zp} * {(RW-OPS_W)'(0), r_s2_b};
            r_s3_pc    <= {(RW-8)'(0), r_zp_sq} * {(RW-CW)'(0), r_s2_count};
            r_s3_count <= r_s2_count;
            r_s3_over  <= r_s2_over;
        end
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    logic [RW-1:0] n_result;

    // modular combination, truncated to the result width
    assign n_result = r_centered ? (r_s3_psum - r_s3_pa - r_s3_pb + r_s3_pc) : r_s3_psum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_out.dot_result    <= $signed(n_result);
            o_out.element_total <= r_s3_count;
            o_out.overflow      <= r_s3_over;
        end
    end

    assign o_valid = r_out_valid;

`ifndef SYNTHESIS
    // the count never goes past the length limit
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_pair_count} <= (CW+1)'(MAX_LEN))
        else $error("pair count above length limit");

    // a closed dot product leaves cleared state behind
    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && s1_last) |=> (r_pair_count == '0 && !r_overflow && r_product_sum == '0))
        else $error("accumulator not cleared after last group");

    // overflow is only raised by an advancing group
    a_overflow_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_overflow) |-> $past(s1_fire && grp_over))
        else $error("overflow set without a refused group");

    // a finished snapshot reaches the output one stage later unless stalled
    a_result_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_valid && en) |=> r_out_valid)
        else $error("result dropped before output register");
`endif

endmodule

`default_nettype wire

// File: dv/tb_uint4_dot_product_accumulator_core.sv
// self-checking testbench for the uint4 dot product accumulator core
`timescale 1ns / 1ps

module tb_uint4_dot_product_accumulator_core;

    localparam int unsigned     LANES    = 16;
    localparam int unsigned     MAX_LEN  = 65536;
    localparam int unsigned     SETTLE   = 10;
    localparam longint unsigned LIMIT    = 2_000_000;
    localparam logic [63:0]     ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // running dot product totals and the result beats still owed by the block
    class dot_sum_board;
        logic                 centered;
        logic [3:0]           zp;
        logic [23:0]          prod_acc;
        logic [19:0]          a_acc;
        logic [19:0]          b_acc;
        logic [16:0]          pairs;
        logic                 refused;
        uda_pkg::t_out_beat   pending_dots[$];
        int unsigned          errors;
        int unsigned          matched;

        function new();
            centered = 1'b0;
            zp       = uda_pkg::ZERO_POINT_RESET;
            errors   = 0;
            matched  = 0;
            clear_dot();
        endfunction

        function void clear_dot();
            prod_acc = '0;
            a_acc    = '0;
            b_acc    = '0;
            pairs    = '0;
            refused  = 1'b0;
        endfunction

        function void set_mode(logic [31:0] w);
            centered = w[0];
        endfunction

        function void set_zp(logic [31:0] w);
            zp = w[3:0];
        endfunction

        // fold one accepted group into the totals, close the dot product on last
        function void take_group(uda_pkg::t_in_beat g);
            int unsigned        lanes;
            int unsigned        psum;
            int unsigned        asum;
            int unsigned        bsum;
            int unsigned        av;
            int unsigned        bv;
            int unsigned        i;
            longint             dot;
            longint             z;
            uda_pkg::t_out_beat r;
            lanes = (g.valid_lanes > LANES) ? LANES : int'(g.valid_lanes);
            psum  = 0;
            asum  = 0;
            bsum  = 0;
            for (i = 0; i < lanes; i++) begin
                av   = int'(g.a_nibbles[4*i +: 4]);
                bv   = int'(g.b_nibbles[4*i +: 4]);
                psum += av * bv;
                asum += av;
                bsum += bv;
            end
            // a group that would pass the length limit is dropped whole
            if (int'(pairs) + lanes > MAX_LEN) begin
                refused = 1'b1;
            end else begin
                prod_acc = prod_acc + psum[23:0];
                a_acc    = a_acc + asum[19:0];
                b_acc    = b_acc + bsum[19:0];
                pairs    = pairs + lanes[16:0];
            end
            if (!g.last_group) return;
            dot = longint'(prod_acc);
            if (centered) begin
                z   = longint'(zp);
                dot = dot - z * longint'(a_acc) - z * longint'(b_acc)
                    + z * z * longint'(pairs);
            end
            r.dot_result    = dot[24:0];
            r.element_total = pairs;
            r.overflow      = refused;
            pending_dots.push_back(r);
            clear_dot();
        endfunction

        // compare one result beat with the oldest owed one
        function void match_result(uda_pkg::t_out_beat got);
            uda_pkg::t_out_beat want;
            if (pending_dots.size() == 0) begin
                $display("%0t: result beat with none owed: dot %0d total %0d ovf %0b",
                         $time, got.dot_result, got.element_total, got.overflow);
                errors++;
                return;
            end
            want = pending_dots.pop_front();
            matched++;
            if (got.dot_result !== want.dot_result) begin
                $display("%0t: dot_result expected %0d actual %0d",
                         $time, want.dot_result, got.dot_result);
                errors++;
            end
            if (got.element_total !== want.element_total) begin
                $display("%0t: element_total expected %0d actual %0d",
                         $time, want.element_total, got.element_total);
                errors++;
            end
            if (got.overflow !== want.overflow) begin
                $display("%0t: overflow expected %0b actual %0b",
                         $time, want.overflow, got.overflow);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    uda_pkg::t_in_beat  i_in;
    logic               o_valid;
    logic               i_stall;
    uda_pkg::t_out_beat o_out;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    dot_sum_board    sb;
    logic            gaps_quiet  = 1'b0;
    logic            stall_quiet = 1'b0;
    int unsigned     beats_sent  = 0;
    longint unsigned cycle_cnt   = 0;

    uint4_dot_product_accumulator_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT) begin
            $display("[uint4_dot_product_accumulator_core] ERROR");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [63:0] rand_nibbles();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) return ALL_ONES;
        if (pick < 12) return 64'h0;
        return {$urandom, $urandom};
    endfunction

    function automatic uda_pkg::t_in_beat grp(input logic [63:0] a, input logic [63:0] b,
                                              input logic [4:0] n, input logic last);
        uda_pkg::t_in_beat g;
        g.a_nibbles   = a;
        g.b_nibbles   = b;
        g.valid_lanes = n;
        g.last_group  = last;
        return g;
    endfunction

    // random group: mostly full width, some tails, some oversized or empty counts
    function automatic uda_pkg::t_in_beat rand_group(input logic last);
        int unsigned pick;
        logic [4:0]  n;
        pick = $urandom_range(0, 99);
        if (pick < 70) n = 5'd16;
        else if (pick < 85) n = 5'($urandom_range(1, 15));
        else if (pick < 93) n = 5'($urandom_range(17, 31));
        else n = 5'd0;
        return grp(rand_nibbles(), rand_nibbles(), n, last);
    endfunction

    function automatic int unsigned dot_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) return $urandom_range(1, 6);
        if (pick < 95) return $urandom_range(7, 20);
        return $urandom_range(21, 60);
    endfunction

    // result side back-pressure
    initial begin
        int unsigned free_len;
        int unsigned stall_len;
        i_stall = 1'b0;
        forever begin
            free_len  = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 6)
                                                    : $urandom_range(20, 80);
            repeat (free_len) @(negedge i_clk) i_stall <= 1'b0;
            stall_len = stall_quiet ? 0 : idle_len();
            repeat (stall_len) @(negedge i_clk) i_stall <= 1'b1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.match_result(o_out);
    end

    // send one group beat, after an optional gap
    task automatic send_group(input uda_pkg::t_in_beat g);
        int unsigned gap;
        gap = gaps_quiet ? 0 : idle_len();
        repeat (gap) @(negedge i_clk) i_valid <= 1'b0;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_in    <= g;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.take_group(g);
        beats_sent++;
    endtask

    // stop sending and wait for every owed result
    task automatic drain_results();
        @(negedge i_clk) i_valid <= 1'b0;
        while (sb.pending_dots.size() != 0) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk) penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_check(input logic [2:0] addr, input logic [31:0] want);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk) penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== want) begin
            $display("%0t: register 0x%0h expected 0x%0h actual 0x%0h",
                     $time, addr, want, prdata);
            sb.errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write both registers once the pipeline has emptied, then read them back
    task automatic set_config(input logic [31:0] mode_w, input logic [31:0] zp_w);
        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        apb_write(uda_pkg::ADDR_CENTERED_MODE, mode_w);
        sb.set_mode(mode_w);
        apb_write(uda_pkg::ADDR_ZERO_POINT, zp_w);
        sb.set_zp(zp_w);
        apb_check(uda_pkg::ADDR_CENTERED_MODE, {31'b0, mode_w[0]});
        apb_check(uda_pkg::ADDR_ZERO_POINT, {28'b0, zp_w[3:0]});
    endtask

    // stimulus
    initial begin
        int unsigned p;
        int unsigned k;
        int unsigned len;
        int unsigned phase_items;
        logic        pressured;
        logic [31:0] mode_w;
        logic [31:0] zp_w;
        sb        = new();
        pressured = 1'b0;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_in      = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // reset values of the registers
        apb_check(uda_pkg::ADDR_CENTERED_MODE, 32'd0);
        apb_check(uda_pkg::ADDR_ZERO_POINT, {28'b0, uda_pkg::ZERO_POINT_RESET});

        // empty dot product, then the widest raw products
        send_group(grp(64'h0, 64'h0, 5'd0, 1'b1));
        send_group(grp(ALL_ONES, ALL_ONES, 5'd16, 1'b1));
        send_group(grp(64'h0, ALL_ONES, 5'd16, 1'b0));
        send_group(grp(ALL_ONES, 64'h0, 5'd16, 1'b1));
        // oversized lane counts saturate, zero lanes add nothing
        send_group(grp(64'h5A5A_5A5A_5A5A_5A5A, 64'hA5A5_A5A5_A5A5_A5A5, 5'd31, 1'b1));
        send_group(grp(rand_nibbles(), rand_nibbles(), 5'd17, 1'b0));
        send_group(grp(ALL_ONES, ALL_ONES, 5'd0, 1'b0));
        send_group(grp(rand_nibbles(), rand_nibbles(), 5'd1, 1'b1));
        send_group(grp(rand_nibbles(), rand_nibbles(), 5'd5, 1'b1));
        send_group(grp(rand_nibbles(), rand_nibbles(), 5'd15, 1'b1));
        // dot product left open across a mode change, mode applies at the last beat
        send_group(grp(ALL_ONES, 64'h0123_4567_89AB_CDEF, 5'd16, 1'b0));
        set_config(32'hFFFF_FFFF, 32'h7654_321F);
        send_group(grp(64'h0, 64'h0, 5'd0, 1'b1));
        send_group(grp(64'h0, 64'h0, 5'd16, 1'b1));
        send_group(grp(ALL_ONES, 64'h0, 5'd16, 1'b1));
        set_config(32'h0000_0003, 32'hFFFF_FFF0);
        send_group(grp(ALL_ONES, ALL_ONES, 5'd16, 1'b1));
        send_group(grp(64'h0F0F_0F0F_0F0F_0F0F, 64'hF0F0_F0F0_F0F0_F0F0, 5'd16, 1'b1));
        set_config(32'h8000_0000, 32'h0000_00F7);
        send_group(grp(rand_nibbles(), rand_nibbles(), 5'd16, 1'b1));

        // random dot products under several register settings
        for (p = 0; p < 6; p++) begin
            mode_w    = $urandom;
            zp_w      = $urandom;
            mode_w[0] = (p == 0) ? 1'b0 : (p < 3) ? 1'b1 : 1'($urandom_range(0, 1));
            zp_w[3:0] = (p == 1) ? 4'd0 : (p < 3) ? 4'd15 : 4'($urandom_range(0, 15));
            set_config(mode_w, zp_w);
            gaps_quiet  = (p == 3);
            stall_quiet = (p == 3);
            phase_items = 0;
            while (phase_items < 70) begin
                len = dot_len();
                for (k = 0; k < len; k++) send_group(rand_group(k == len - 1));
                phase_items += len;
                // sender holds off until the block has handed back everything
                if (p == 2 && !pressured && phase_items > 30) begin
                    drain_results();
                    pressured = 1'b1;
                end
            end
        end
        gaps_quiet  = 1'b0;
        stall_quiet = 1'b0;

        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        $display("%0d group beats sent, %0d dot products checked", beats_sent, sb.matched);
        $display("raw and centered modes, lane tails and saturation, register readback");
        if (sb.errors == 0) begin
            $display("[uint4_dot_product_accumulator_core] OK");
        end else begin
            $display("[uint4_dot_product_accumulator_core] ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/uda_pkg.sv
hw/rtl/uda_lane.sv
hw/rtl/uda_merge.sv
hw/rtl/uint4_dot_product_accumulator_core.sv
dv/tb_uint4_dot_product_accumulator_core.sv
